/* hdl/circular_fifo_queue_top_defines.svh */
// Assertion macros for the checker file of the queue.
`ifndef CIRCULAR_FIFO_QUEUE_TOP_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_TOP_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define CFQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define CFQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/cfq_pkg.sv */
`default_nettype none

package cfq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned SIZE_RESET = 16;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_ENQ        = 2'd0,
    ACT_DEQ        = 2'd1,
    ACT_PEEK_FRONT = 2'd2,
    ACT_PEEK_REAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Slot store access issued by the controller.
  typedef struct packed {
    logic  we;
    logic  re;
    idx_t  addr;
    word_t wdata;
  } mem_req_t;

  // Result word fields registered by the controller.
  typedef struct packed {
    logic    valid;
    logic    rd_ok;
    status_e status;
    cnt_t    count;
  } res_t;

  // Saturate a raw size write to 1..DEPTH.
  function automatic cnt_t clamp_size(logic [CFG_W-1:0] v);
    logic [CFG_W:0] s;
    s = {1'b0, v};
    if (s < (CFG_W+1)'(1)) begin
      s = (CFG_W+1)'(1);
    end
    if (32'(s) > DEPTH) begin
      return cnt_t'(DEPTH);
    end
    return cnt_t'(s);
  endfunction

  // Step an index, wrapping to slot 0 at the configured size.
  function automatic idx_t next_index(idx_t i, cnt_t size);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(i) + (CNT_W+1)'(1);
    if (n >= (CNT_W+1)'(size) || 32'(n) >= DEPTH) begin
      return idx_t'(0);
    end
    return idx_t'(n);
  endfunction

endpackage

`default_nettype wire

/* hdl/cfq_ram.sv */
`default_nettype none

module cfq_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/cfq_ctrl.sv */
`default_nettype none

module cfq_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [1:0]                 action_i,
  input  wire cfq_pkg::word_t             word_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [cfq_pkg::CFG_W-1:0]  cfg_data_i,
  output cfq_pkg::mem_req_t               mem_req_o,
  output cfq_pkg::res_t                   res_o
);

  cfq_pkg::cnt_t    size_q;
  cfq_pkg::cnt_t    count_q, count_d;
  cfq_pkg::idx_t    rd_idx_q, rd_idx_d;
  cfq_pkg::idx_t    lw_idx_q, lw_idx_d;
  cfq_pkg::res_t    res_q, res_d;
  cfq_pkg::mem_req_t req;
  logic             full, empty;

  // Hold the size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= cfq_pkg::clamp_size(cfq_pkg::CFG_W'(cfq_pkg::SIZE_RESET));
    end else if (cfg_we_i) begin
      size_q <= cfq_pkg::clamp_size(cfg_data_i);
    end
  end

  assign full  = (count_q >= size_q);
  assign empty = (count_q == '0);

  // Decode the operation, update the indices and issue the slot access.
  always_comb begin
    count_d      = count_q;
    rd_idx_d     = rd_idx_q;
    lw_idx_d     = lw_idx_q;
    req.we       = 1'b0;
    req.re       = 1'b0;
    req.addr     = rd_idx_q;
    req.wdata    = word_i;
    res_d.valid  = accept_i;
    res_d.rd_ok  = 1'b0;
    res_d.status = cfq_pkg::ST_OK;
    if (accept_i) begin
      unique case (cfq_pkg::action_e'(action_i))
        cfq_pkg::ACT_ENQ: begin
          if (full) begin
            res_d.status = cfq_pkg::ST_FULL;
          end else begin
            if (empty) begin
              rd_idx_d = '0;
              lw_idx_d = '0;
            end else begin
              lw_idx_d = cfq_pkg::next_index(lw_idx_q, size_q);
            end
            req.we   = 1'b1;
            req.addr = lw_idx_d;
            count_d  = count_q + cfq_pkg::cnt_t'(1);
          end
        end
        cfq_pkg::ACT_DEQ: begin
          if (empty) begin
            res_d.status = cfq_pkg::ST_EMPTY;
          end else begin
            req.re      = 1'b1;
            req.addr    = rd_idx_q;
            res_d.rd_ok = 1'b1;
            if (count_q == cfq_pkg::cnt_t'(1)) begin
              rd_idx_d = '0;
              lw_idx_d = '0;
            end else begin
              rd_idx_d = cfq_pkg::next_index(rd_idx_q, size_q);
            end
            count_d = count_q - cfq_pkg::cnt_t'(1);
          end
        end
        cfq_pkg::ACT_PEEK_FRONT: begin
          if (empty) begin
            res_d.status = cfq_pkg::ST_EMPTY;
          end else begin
            req.re      = 1'b1;
            req.addr    = rd_idx_q;
            res_d.rd_ok = 1'b1;
          end
        end
        cfq_pkg::ACT_PEEK_REAR: begin
          if (empty) begin
            res_d.status = cfq_pkg::ST_EMPTY;
          end else begin
            req.re      = 1'b1;
            req.addr    = lw_idx_q;
            res_d.rd_ok = 1'b1;
          end
        end
        default: begin
          res_d.status = cfq_pkg::ST_OK;
        end
      endcase
    end
    res_d.count = count_d;
  end

  // Advance the queue state and register the result word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      lw_idx_q <= '0;
      res_q    <= '0;
    end else begin
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      lw_idx_q <= lw_idx_d;
      res_q    <= res_d;
    end
  end

  assign mem_req_o = req;
  assign res_o     = res_q;

endmodule

`default_nettype wire

/* hdl/circular_fifo_queue_top.sv */
// Ring-buffer queue of up to 16 words of 32 bits.
//
// Command channel: drive action_i and data_in_i with start_i high; the word
// is taken at the rising edge where start_i is high and busy_o is low.
// busy_o stays low, so a new command may be given in every cycle.
// Actions: enqueue, dequeue, peek front, peek rear.
//
// Result channel: exactly one result word per command, shown on status_o,
// data_out_o and count_out_o for one cycle while done_o is high, in the cycle
// after the command was taken. The receiver cannot stall the results.
// Read data comes from the registered read port of the slot memory;
// throughput is one command per cycle.
//
// Configuration: cfg_we_i writes cfg_data_i into the size register at once
// (0 acts as 1, above 16 acts as 16). Change it only while the queue is empty.
//
// Reset (rst_ni low) empties the queue and sets the size to 16; the slot
// memory is not cleared, and no slot is read before it was written.
`default_nettype none

module circular_fifo_queue_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   action_i,
  input  wire logic [cfq_pkg::FIELD_W-1:0]  data_in_i,
  output logic                              done_o,
  output logic      [1:0]                   status_o,
  output logic      [cfq_pkg::FIELD_W-1:0]  data_out_o,
  output logic      [cfq_pkg::CNT_W-1:0]    count_out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [cfq_pkg::CFG_W-1:0]    cfg_data_i
);

  cfq_pkg::mem_req_t mem_req;
  cfq_pkg::res_t     res;
  cfq_pkg::word_t    rdata;
  logic              accept;

  // Commands are taken in every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  cfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (action_i),
    .word_i     (cfq_pkg::word_t'(data_in_i)),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .mem_req_o  (mem_req),
    .res_o      (res)
  );

  cfq_ram #(
    .DEPTH (cfq_pkg::DEPTH),
    .WIDTH (cfq_pkg::DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  // Drive the result word; data is zero unless a read succeeded.
  assign done_o      = res.valid;
  assign status_o    = res.status;
  assign count_out_o = res.count;
  assign data_out_o  = res.rd_ok ? cfq_pkg::FIELD_W'(rdata) : '0;

endmodule

`default_nettype wire

/* hdl/cfq_checker.sv */
`default_nettype none
`include "circular_fifo_queue_top_defines.svh"

module cfq_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic [1:0]                   action_i,
  input wire logic [cfq_pkg::FIELD_W-1:0]  data_in_i,
  input wire logic                         done_o,
  input wire logic [1:0]                   status_o,
  input wire logic [cfq_pkg::FIELD_W-1:0]  data_out_o,
  input wire logic [cfq_pkg::CNT_W-1:0]    count_out_o,
  input wire logic                         cfg_we_i,
  input wire logic [cfq_pkg::CFG_W-1:0]    cfg_data_i
);

  // Each accepted command yields a result in the next cycle, and only then.
  `CFQ_ASSERT(a_result_follows, (rst_ni && start_i && !busy_o) |=> done_o, "result missing")
  `CFQ_ASSERT(a_no_extra_result, (rst_ni && !(start_i && !busy_o)) |=> !done_o, "extra result")

  // A refused operation and any enqueue return zero data.
  `CFQ_ASSERT(a_refused_zero, (done_o && status_o != 2'(cfq_pkg::ST_OK)) |-> (data_out_o == '0), "refused data not zero")
  `CFQ_ASSERT(a_enq_zero, (done_o && $past(action_i) == 2'(cfq_pkg::ACT_ENQ)) |-> (data_out_o == '0), "enqueue data not zero")

  // The count never exceeds the store depth.
  `CFQ_ASSERT(a_count_range, done_o |-> (32'(count_out_o) <= cfq_pkg::DEPTH), "count out of range")

endmodule

bind circular_fifo_queue_top cfq_checker u_cfq_checker (.*);

`default_nettype wire
